// File: sv/twi_master_event_sequencer_macros.svh
// Assertion macros shared by the checker of the two-wire master event sequencer.
`ifndef TWI_MASTER_EVENT_SEQUENCER_MACROS_SVH
`define TWI_MASTER_EVENT_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TMES_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmes check failed");

// Next-cycle implication, disabled while reset is low.
`define TMES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmes check failed");

`endif

// File: sv/tmes_pkg.sv
// Shared codes, defaults and result word type of the two-wire master event sequencer.
`timescale 1ns / 1ps

package tmes_pkg;

    localparam int DEF_BUF_DEPTH = 16;

    // Item kinds
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_EVENT = 2'd2;

    // Bus status codes
    localparam logic [3:0] ST_START         = 4'd0;
    localparam logic [3:0] ST_REP_START     = 4'd1;
    localparam logic [3:0] ST_MT_ADDR_ACK   = 4'd2;
    localparam logic [3:0] ST_MT_ADDR_NACK  = 4'd3;
    localparam logic [3:0] ST_MT_DATA_ACK   = 4'd4;
    localparam logic [3:0] ST_MT_DATA_NACK  = 4'd5;
    localparam logic [3:0] ST_ARB_LOST      = 4'd6;
    localparam logic [3:0] ST_MR_ADDR_ACK   = 4'd7;
    localparam logic [3:0] ST_MR_ADDR_NACK  = 4'd8;
    localparam logic [3:0] ST_MR_DATA_ACK   = 4'd9;
    localparam logic [3:0] ST_MR_DATA_NACK  = 4'd10;
    localparam logic [3:0] ST_BUS_ERROR     = 4'd11;
    localparam logic [3:0] ST_NO_INFO       = 4'd12;

    typedef struct packed {
        logic       start_cond;
        logic       stop_cond;
        logic       ack_next;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_valid;
        logic [3:0] rx_index;
        logic [7:0] rx_byte;
        logic       done_res;
    } t_result;

endpackage

// File: sv/twi_master_event_sequencer.sv
// Top level of the two-wire master event sequencer: input register, state, send buffer, output word.
`timescale 1ns / 1ps
// Use:
//   Input channel (i_in_valid / o_in_ready) carries one word per item: a load of a
//   send byte into the buffer, a transfer start, or a bus status event.
//   Output channel (o_out_valid / i_out_ready) carries the action word: start or
//   stop request, ack enable, a byte to shift out, a received byte with its index,
//   and the done mark. Loads, "no info" events and the unused kind give no word.
// Timing:
//   An accepted word sits in the input register while the decision logic runs;
//   its action word is then loaded into the output register and offered there.
//   Throughput is one word per cycle while the output word is not stalled; the
//   rate is set by the single decision pass between the input register and the
//   output register.
//   The send buffer is a memory with a registered read port that always holds the
//   byte at the current send position (written bytes are forwarded).
// Reset (i_rst_n low, synchronous): both registers empty, transfer state cleared.
//   The send buffer is not cleared; it must be loaded before a transfer reads it.
// Stall: while the output word waits, the input register still drains words that
//   give no result, and a new word is taken as soon as the output word leaves.
module twi_master_event_sequencer #(
    parameter int BUF_DEPTH = tmes_pkg::DEF_BUF_DEPTH,
    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_kind,
    input  logic [3:0] i_buf_index,
    input  logic [7:0] i_data_byte,
    input  logic [6:0] i_slave_addr,
    input  logic       i_is_read,
    input  logic [4:0] i_byte_count,
    input  logic [3:0] i_bus_status,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_start_cond,
    output logic       o_stop_cond,
    output logic       o_ack_next,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_rx_valid,
    output logic [3:0] o_rx_index,
    output logic [7:0] o_rx_byte,
    output logic       o_done_res
);
    import tmes_pkg::*;

    // Input register
    logic       r_in_valid;
    logic [1:0] r_kind;
    logic [3:0] r_buf_index;
    logic [7:0] r_data_byte;
    logic [6:0] r_slave_addr;
    logic       r_is_read;
    logic [4:0] r_byte_count;
    logic [3:0] r_bus_status;

    // Transfer state
    logic          r_transmit_mode;
    logic [6:0]    r_target_addr;
    logic [7:0]    r_bytes_left;
    logic [AW-1:0] r_send_pos;
    logic [AW-1:0] r_recv_pos;
    logic [AW-1:0] n_send_pos;

    // Send buffer and its registered read port
    logic [7:0] r_store [BUF_DEPTH];
    logic [7:0] r_rd_data;

    // Output register
    logic    r_out_valid;
    t_result r_out;

    // Decision outputs
    logic          dec_has_result;
    t_result       dec_result;
    logic          dec_transmit_mode;
    logic [6:0]    dec_target_addr;
    logic [7:0]    dec_bytes_left;
    logic [AW-1:0] dec_send_pos;
    logic [AW-1:0] dec_recv_pos;
    logic          dec_wr_en;
    logic [AW-1:0] dec_wr_addr;
    logic [7:0]    dec_wr_data;

    logic w_advance;
    logic w_wr_fire;

    tmes_decide #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_decide (
        .i_kind          (r_kind),
        .i_buf_index     (r_buf_index),
        .i_data_byte     (r_data_byte),
        .i_slave_addr    (r_slave_addr),
        .i_is_read       (r_is_read),
        .i_byte_count    (r_byte_count),
        .i_bus_status    (r_bus_status),
        .i_transmit_mode (r_transmit_mode),
        .i_target_addr   (r_target_addr),
        .i_bytes_left    (r_bytes_left),
        .i_send_pos      (r_send_pos),
        .i_recv_pos      (r_recv_pos),
        .i_send_data     (r_rd_data),
        .o_has_result    (dec_has_result),
        .o_result        (dec_result),
        .o_transmit_mode (dec_transmit_mode),
        .o_target_addr   (dec_target_addr),
        .o_bytes_left    (dec_bytes_left),
        .o_send_pos      (dec_send_pos),
        .o_recv_pos      (dec_recv_pos),
        .o_wr_en         (dec_wr_en),
        .o_wr_addr       (dec_wr_addr),
        .o_wr_data       (dec_wr_data)
    );

    // Advance the held word unless it has a result and the output slot stays full.
    assign w_advance  = r_in_valid && (!dec_has_result || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;
    assign w_wr_fire  = w_advance && dec_wr_en;

    // Send position after this edge; the read port follows it.
    always_comb begin
        if (!i_rst_n) begin
            n_send_pos = '0;
        end else if (w_advance) begin
            n_send_pos = dec_send_pos;
        end else begin
            n_send_pos = r_send_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_transmit_mode <= 1'b0;
            r_target_addr   <= '0;
            r_bytes_left    <= '0;
            r_send_pos      <= '0;
            r_recv_pos      <= '0;
        end else begin
            // Input register: take a word whenever the held one moves on.
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end

            // Commit the state update of the word that advances.
            if (w_advance) begin
                r_transmit_mode <= dec_transmit_mode;
                r_target_addr   <= dec_target_addr;
                r_bytes_left    <= dec_bytes_left;
                r_recv_pos      <= dec_recv_pos;
            end
            r_send_pos <= n_send_pos;

            // Output register: load a fresh word, or drop the taken one.
            if (w_advance && dec_has_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_kind       <= i_kind;
            r_buf_index  <= i_buf_index;
            r_data_byte  <= i_data_byte;
            r_slave_addr <= i_slave_addr;
            r_is_read    <= i_is_read;
            r_byte_count <= i_byte_count;
            r_bus_status <= i_bus_status;
        end
        if (w_advance && dec_has_result) begin
            r_out <= dec_result;
        end
    end

    // Send buffer: one write port, one registered read port with write forwarding.
    always_ff @(posedge i_clk) begin
        if (w_wr_fire) begin
            r_store[dec_wr_addr] <= dec_wr_data;
        end
        if (w_wr_fire && (dec_wr_addr == n_send_pos)) begin
            r_rd_data <= dec_wr_data;
        end else begin
            r_rd_data <= r_store[n_send_pos];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_start_cond = r_out.start_cond;
    assign o_stop_cond  = r_out.stop_cond;
    assign o_ack_next   = r_out.ack_next;
    assign o_tx_valid   = r_out.tx_valid;
    assign o_tx_byte    = r_out.tx_byte;
    assign o_rx_valid   = r_out.rx_valid;
    assign o_rx_index   = r_out.rx_index;
    assign o_rx_byte    = r_out.rx_byte;
    assign o_done_res   = r_out.done_res;

endmodule

// File: sv/tmes_decide.sv
// Next-action decision for one registered item: result word and next transfer state.
`timescale 1ns / 1ps

module tmes_decide #(
    parameter int BUF_DEPTH = tmes_pkg::DEF_BUF_DEPTH,
    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1
) (
    input  logic [1:0]        i_kind,
    input  logic [3:0]        i_buf_index,
    input  logic [7:0]        i_data_byte,
    input  logic [6:0]        i_slave_addr,
    input  logic              i_is_read,
    input  logic [4:0]        i_byte_count,
    input  logic [3:0]        i_bus_status,
    input  logic              i_transmit_mode,
    input  logic [6:0]        i_target_addr,
    input  logic [7:0]        i_bytes_left,
    input  logic [AW-1:0]     i_send_pos,
    input  logic [AW-1:0]     i_recv_pos,
    input  logic [7:0]        i_send_data,
    output logic              o_has_result,
    output tmes_pkg::t_result o_result,
    output logic              o_transmit_mode,
    output logic [6:0]        o_target_addr,
    output logic [7:0]        o_bytes_left,
    output logic [AW-1:0]     o_send_pos,
    output logic [AW-1:0]     o_recv_pos,
    output logic              o_wr_en,
    output logic [AW-1:0]     o_wr_addr,
    output logic [7:0]        o_wr_data
);
    import tmes_pkg::*;

    logic [7:0]    bytes_dec;
    logic [AW-1:0] send_adv;
    logic [AW-1:0] recv_adv;
    logic [8:0]    recv_ext;
    logic          load_in_range;

    assign bytes_dec     = i_bytes_left - 8'd1;
    assign send_adv      = (i_send_pos == AW'(BUF_DEPTH - 1)) ? '0 : i_send_pos + AW'(1);
    assign recv_adv      = (i_recv_pos == AW'(BUF_DEPTH - 1)) ? '0 : i_recv_pos + AW'(1);
    assign recv_ext      = 9'(i_recv_pos);
    assign load_in_range = ({28'd0, i_buf_index} < BUF_DEPTH);

    assign o_wr_addr = AW'(i_buf_index);
    assign o_wr_data = i_data_byte;

    always_comb begin
        o_has_result    = 1'b0;
        o_result        = '0;
        o_transmit_mode = i_transmit_mode;
        o_target_addr   = i_target_addr;
        o_bytes_left    = i_bytes_left;
        o_send_pos      = i_send_pos;
        o_recv_pos      = i_recv_pos;
        o_wr_en         = 1'b0;

        unique case (i_kind)
            KIND_LOAD: begin
                o_wr_en = load_in_range;
            end
            KIND_START: begin
                o_has_result        = 1'b1;
                o_result.start_cond = 1'b1;
                o_transmit_mode     = ~i_is_read;
                o_target_addr       = i_slave_addr;
                o_bytes_left        = {3'd0, i_byte_count};
                if (!i_is_read) begin
                    o_send_pos = '0;
                end else begin
                    o_recv_pos = '0;
                end
            end
            KIND_EVENT: begin
                o_has_result = 1'b1;
                case (i_bus_status) inside
                    ST_START, ST_REP_START: begin
                        o_result.tx_valid = 1'b1;
                        o_result.tx_byte  = {i_target_addr, ~i_transmit_mode};
                    end
                    ST_MT_ADDR_ACK, ST_MT_DATA_ACK: begin
                        // Send the next buffered byte, or finish when none is left.
                        if (i_bytes_left == 8'd0) begin
                            o_result.stop_cond = 1'b1;
                            o_result.done_res  = 1'b1;
                        end else begin
                            o_result.tx_valid = 1'b1;
                            o_result.tx_byte  = i_send_data;
                            o_bytes_left      = bytes_dec;
                            o_send_pos        = send_adv;
                        end
                    end
                    ST_MT_ADDR_NACK: begin
                        if (i_bytes_left != 8'd0) begin
                            o_result.start_cond = 1'b1;
                        end else begin
                            o_result.stop_cond = 1'b1;
                            o_result.done_res  = 1'b1;
                        end
                    end
                    ST_MT_DATA_NACK: begin
                        o_result.ack_next  = 1'b1;
                        o_result.stop_cond = 1'b1;
                        o_result.done_res  = 1'b1;
                    end
                    ST_ARB_LOST: begin
                        o_result.start_cond = 1'b1;
                        o_result.ack_next   = 1'b1;
                    end
                    ST_MR_ADDR_ACK: begin
                        o_result.ack_next = (i_bytes_left > 8'd1);
                    end
                    ST_MR_ADDR_NACK: begin
                        o_result.start_cond = 1'b1;
                    end
                    ST_MR_DATA_ACK: begin
                        o_result.rx_valid = 1'b1;
                        o_result.rx_index = recv_ext[3:0];
                        o_result.rx_byte  = i_data_byte;
                        o_bytes_left      = bytes_dec;
                        o_recv_pos        = recv_adv;
                        o_result.ack_next = (bytes_dec != 8'd1);
                    end
                    ST_MR_DATA_NACK: begin
                        o_result.rx_valid  = 1'b1;
                        o_result.rx_index  = recv_ext[3:0];
                        o_result.rx_byte   = i_data_byte;
                        o_result.stop_cond = 1'b1;
                        o_result.done_res  = 1'b1;
                    end
                    ST_BUS_ERROR: begin
                        o_result.stop_cond = 1'b1;
                        o_result.done_res  = 1'b1;
                    end
                    ST_NO_INFO: begin
                        o_has_result = 1'b0;
                    end
                    default: begin
                        o_result.ack_next  = 1'b1;
                        o_result.stop_cond = 1'b1;
                        o_result.done_res  = 1'b1;
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

endmodule

// File: sv/tmes_checker.sv
// Port checker of the two-wire master event sequencer and its bind to the top level.
`timescale 1ns / 1ps
`include "twi_master_event_sequencer_macros.svh"

module tmes_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_start_cond,
    input logic       o_stop_cond,
    input logic       o_ack_next,
    input logic       o_tx_valid,
    input logic [7:0] o_tx_byte,
    input logic       o_rx_valid,
    input logic [3:0] o_rx_index,
    input logic [7:0] o_rx_byte,
    input logic       o_done_res
);

    logic        w_stall;
    logic [26:0] w_word;
    logic        w_rx_zero;

    assign w_stall   = o_out_valid && !i_out_ready;
    assign w_word    = {o_start_cond, o_stop_cond, o_ack_next, o_tx_valid, o_tx_byte,
                        o_rx_valid, o_rx_index, o_rx_byte, o_done_res};
    assign w_rx_zero = (o_rx_index == 4'd0) && (o_rx_byte == 8'd0);

    // A stalled output word holds.
    `TMES_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, o_out_valid && $stable(w_word))

    // Done always comes with a stop request.
    `TMES_ASSERT_NOW(a_done_stop, i_clk, i_rst_n, o_out_valid && o_done_res, o_stop_cond)

    // A delivered byte never shares a word with a send or a start.
    `TMES_ASSERT_NOW(a_rx_alone, i_clk, i_rst_n, o_out_valid && o_rx_valid, !o_tx_valid && !o_start_cond)

    // Receive fields are clear unless a byte is delivered.
    `TMES_ASSERT_NOW(a_rx_clear, i_clk, i_rst_n, o_out_valid && !o_rx_valid, w_rx_zero)

endmodule

bind twi_master_event_sequencer tmes_checker u_tmes_checker (.*);

// File: tb/twi_master_event_sequencer_tb.sv
// Self-checking testbench for the two-wire master event sequencer.
`timescale 1ns / 1ps

module twi_master_event_sequencer_tb;
    import tmes_pkg::*;

    // Codes the package leaves unnamed: the spare item kind and the
    // unlisted status codes, which all act as "other".
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [3:0] ST_OTHER    = 4'd13;
    localparam logic [3:0] ST_LAST     = 4'd15;

    localparam int ITEM_TARGET    = 600;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 20;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] buf_index;
        logic [7:0] data_byte;
        logic [6:0] slave_addr;
        logic       is_read;
        logic [4:0] byte_count;
        logic [3:0] bus_status;
    } seq_item_t;

    logic       i_clk;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_kind       = '0;
    logic [3:0] i_buf_index  = '0;
    logic [7:0] i_data_byte  = '0;
    logic [6:0] i_slave_addr = '0;
    logic       i_is_read    = 1'b0;
    logic [4:0] i_byte_count = '0;
    logic [3:0] i_bus_status = '0;
    logic       o_out_valid;
    logic       i_out_ready  = 1'b0;
    logic       o_start_cond;
    logic       o_stop_cond;
    logic       o_ack_next;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic       o_rx_valid;
    logic [3:0] o_rx_index;
    logic [7:0] o_rx_byte;
    logic       o_done_res;

    twi_master_event_sequencer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_buf_index  (i_buf_index),
        .i_data_byte  (i_data_byte),
        .i_slave_addr (i_slave_addr),
        .i_is_read    (i_is_read),
        .i_byte_count (i_byte_count),
        .i_bus_status (i_bus_status),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_start_cond (o_start_cond),
        .o_stop_cond  (o_stop_cond),
        .o_ack_next   (o_ack_next),
        .o_tx_valid   (o_tx_valid),
        .o_tx_byte    (o_tx_byte),
        .o_rx_valid   (o_rx_valid),
        .o_rx_index   (o_rx_index),
        .o_rx_byte    (o_rx_byte),
        .o_done_res   (o_done_res)
    );

    // Words waiting to be offered, and action words still owed by the block.
    seq_item_t stimulus[$];
    t_result   owed_actions[$];
    int        counted_items = 0;
    int        errors        = 0;
    int        words_in      = 0;

    // Sequencer state as the checker sees it.
    logic       xfer_tx   = 1'b0;
    logic [6:0] xfer_addr = '0;
    logic [7:0] xfer_left = '0;
    logic [3:0] send_pos  = '0;
    logic [3:0] recv_pos  = '0;
    logic [7:0] send_buf[DEF_BUF_DEPTH];

    // ------------------------------------------------------------------
    // Next-action predictor
    // ------------------------------------------------------------------

    // End of a transfer: request stop and flag it done.
    function automatic void close_transfer(inout t_result r);
        r.stop_cond = 1'b1;
        r.done_res  = 1'b1;
    endfunction

    // Apply one word to the checker state; return 1 when it yields an action word.
    function automatic bit next_action(input seq_item_t it, output t_result r);
        r = '0;
        case (it.kind)
            KIND_LOAD: begin
                send_buf[it.buf_index] = it.data_byte;
                return 1'b0;
            end
            KIND_START: begin
                xfer_tx   = ~it.is_read;
                xfer_addr = it.slave_addr;
                xfer_left = {3'b000, it.byte_count};
                // only the position of the chosen direction restarts
                if (xfer_tx) begin
                    send_pos = '0;
                end else begin
                    recv_pos = '0;
                end
                r.start_cond = 1'b1;
                return 1'b1;
            end
            KIND_EVENT: begin
                case (it.bus_status)
                    ST_START, ST_REP_START: begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = {xfer_addr, ~xfer_tx};
                    end
                    ST_MT_ADDR_ACK, ST_MT_DATA_ACK: begin
                        if (xfer_left == 8'd0) begin
                            close_transfer(r);
                        end else begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = send_buf[send_pos];
                            xfer_left  = xfer_left - 8'd1;
                            send_pos   = send_pos + 4'd1;
                        end
                    end
                    ST_MT_ADDR_NACK: begin
                        if (xfer_left != 8'd0) begin
                            r.start_cond = 1'b1;
                        end else begin
                            close_transfer(r);
                        end
                    end
                    ST_MT_DATA_NACK: begin
                        r.ack_next = 1'b1;
                        close_transfer(r);
                    end
                    ST_ARB_LOST: begin
                        r.start_cond = 1'b1;
                        r.ack_next   = 1'b1;
                    end
                    ST_MR_ADDR_ACK: begin
                        r.ack_next = (xfer_left > 8'd1);
                    end
                    ST_MR_ADDR_NACK: begin
                        r.start_cond = 1'b1;
                    end
                    ST_MR_DATA_ACK: begin
                        r.rx_valid = 1'b1;
                        r.rx_index = recv_pos;
                        r.rx_byte  = it.data_byte;
                        // bytes left wraps through zero as an 8-bit count
                        xfer_left  = xfer_left - 8'd1;
                        recv_pos   = recv_pos + 4'd1;
                        r.ack_next = (xfer_left != 8'd1);
                    end
                    ST_MR_DATA_NACK: begin
                        r.rx_valid = 1'b1;
                        r.rx_index = recv_pos;
                        r.rx_byte  = it.data_byte;
                        close_transfer(r);
                    end
                    ST_BUS_ERROR: begin
                        close_transfer(r);
                    end
                    ST_NO_INFO: begin
                        return 1'b0;
                    end
                    default: begin
                        // unlisted codes: stop with ack enabled
                        r.ack_next = 1'b1;
                        close_transfer(r);
                    end
                endcase
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic seq_item_t rand_item(input logic [1:0] k);
        seq_item_t it;
        it.kind       = k;
        it.buf_index  = 4'($urandom_range(0, 15));
        it.data_byte  = 8'($urandom_range(0, 255));
        it.slave_addr = 7'($urandom_range(0, 127));
        it.is_read    = 1'($urandom_range(0, 1));
        it.byte_count = 5'($urandom_range(0, 16));
        it.bus_status = 4'($urandom_range(0, 15));
        return it;
    endfunction

    function automatic seq_item_t load_item(input logic [3:0] idx, input logic [7:0] b);
        seq_item_t it;
        it           = rand_item(KIND_LOAD);
        it.buf_index = idx;
        it.data_byte = b;
        return it;
    endfunction

    function automatic seq_item_t start_item(input logic [6:0] addr, input logic rd,
                                             input logic [4:0] cnt);
        seq_item_t it;
        it            = rand_item(KIND_START);
        it.slave_addr = addr;
        it.is_read    = rd;
        it.byte_count = cnt;
        return it;
    endfunction

    function automatic seq_item_t status_item(input logic [3:0] st);
        seq_item_t it;
        it            = rand_item(KIND_EVENT);
        it.bus_status = st;
        return it;
    endfunction

    // Queue a word; ignored words do not count toward the item target.
    task automatic push_item(input seq_item_t it);
        stimulus.push_back(it);
        if (it.kind != KIND_UNUSED &&
            !(it.kind == KIND_EVENT && it.bus_status == ST_NO_INFO)) begin
            counted_items++;
        end
    endtask

    // One well-formed transfer with random content, now and then broken off.
    task automatic add_transfer();
        bit rd;
        int n;
        rd = 1'($urandom_range(0, 1));
        n  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 5);
        if (!rd) begin
            for (int i = 0; i < n; i++) begin
                push_item(load_item(4'(i), 8'($urandom_range(0, 255))));
            end
        end
        push_item(start_item(7'($urandom_range(0, 127)), rd, 5'(n)));
        push_item(status_item(($urandom_range(0, 3) == 0) ? ST_REP_START : ST_START));
        if (!rd) begin
            if ($urandom_range(0, 7) == 0) begin
                push_item(status_item(ST_MT_ADDR_NACK));
                push_item(status_item(ST_BUS_ERROR));
            end else begin
                push_item(status_item(ST_MT_ADDR_ACK));
                for (int i = 1; i < n; i++) begin
                    push_item(status_item(($urandom_range(0, 15) == 0) ?
                                          ST_MT_DATA_NACK : ST_MT_DATA_ACK));
                end
                push_item(status_item(ST_MT_DATA_ACK));
            end
        end else begin
            push_item(status_item(($urandom_range(0, 7) == 0) ?
                                  ST_MR_ADDR_NACK : ST_MR_ADDR_ACK));
            for (int i = 1; i < n; i++) begin
                push_item(status_item(($urandom_range(0, 15) == 0) ?
                                      ST_ARB_LOST : ST_MR_DATA_ACK));
            end
            push_item(status_item(ST_MR_DATA_NACK));
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and verdict
    // ------------------------------------------------------------------

    initial begin
        // Directed opening: field extremes, every status, idle and odd cases.
        push_item(load_item(4'd0, 8'hFF));
        push_item(load_item(4'd1, 8'h00));
        push_item(load_item(4'd15, 8'h5A));
        push_item('1 & {KIND_UNUSED, 4'hF, 8'hFF, 7'h7F, 1'b1, 5'd16, ST_LAST});
        push_item(status_item(ST_NO_INFO));
        push_item(status_item(ST_MT_ADDR_ACK));       // event while idle, nothing left
        push_item(start_item(7'h7F, 1'b0, 5'd2));
        push_item(status_item(ST_START));
        push_item(status_item(ST_MT_ADDR_ACK));
        push_item(status_item(ST_MT_DATA_ACK));
        push_item(status_item(ST_MT_DATA_ACK));       // count exhausted: stop
        push_item(status_item(ST_MT_ADDR_NACK));
        push_item(start_item(7'h00, 1'b1, 5'd16));
        push_item(status_item(ST_REP_START));
        push_item(status_item(ST_MR_ADDR_ACK));
        push_item(load_item(4'd2, 8'h3C) ^ '0);
        stimulus[$].kind = KIND_EVENT;
        stimulus[$].bus_status = ST_MR_DATA_ACK;
        stimulus[$].data_byte = 8'hFF;
        push_item(status_item(ST_MR_DATA_NACK));
        stimulus[$].data_byte = 8'h00;
        push_item(status_item(ST_MT_ADDR_NACK));      // bytes still left: restart
        push_item(status_item(ST_MT_DATA_NACK));
        push_item(status_item(ST_ARB_LOST));
        push_item(status_item(ST_MR_ADDR_NACK));
        push_item(status_item(ST_BUS_ERROR));
        push_item(status_item(ST_OTHER));
        push_item(status_item(ST_LAST));
        push_item(start_item(7'h2A, 1'b1, 5'd0));
        push_item(status_item(ST_MR_DATA_ACK));       // bytes left wraps to 255

        // Fill the whole send buffer so no later send reads an unwritten entry.
        for (int i = 0; i < DEF_BUF_DEPTH; i++) begin
            push_item(load_item(4'(i), 8'($urandom_range(0, 255))));
        end

        // Random part: mostly transfers, the rest noise of any kind and status.
        while (counted_items < ITEM_TARGET) begin
            if ($urandom_range(0, 9) < 7) begin
                add_transfer();
            end else begin
                repeat ($urandom_range(1, 6)) push_item(rand_item(2'($urandom_range(0, 3))));
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every word offered and taken, every action word back.
        while (stimulus.size() != 0 || i_in_valid) @(posedge i_clk);
        while (owed_actions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (errors == 0 && owed_actions.size() == 0) begin
            $display("twi_master_event_sequencer regression: pass");
        end else begin
            $display("twi_master_event_sequencer regression: fail");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: bursts of words with random gaps between them
    // ------------------------------------------------------------------

    int        burst_left = 0;
    int        gap_left   = 0;
    seq_item_t drive_item = '0;

    always @(posedge i_clk) begin : drive_words
        t_result predicted;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // The word on the ports was taken at this edge: predict its action.
            if (i_in_valid && o_in_ready) begin
                if (next_action(drive_item, predicted)) begin
                    owed_actions.push_back(predicted);
                end
                words_in++;
            end
            // Hold the word while it waits; otherwise offer the next one or idle.
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (stimulus.size() != 0) begin
                    drive_item = stimulus.pop_front();
                    i_kind       <= drive_item.kind;
                    i_buf_index  <= drive_item.buf_index;
                    i_data_byte  <= drive_item.data_byte;
                    i_slave_addr <= drive_item.slave_addr;
                    i_is_read    <= drive_item.is_read;
                    i_byte_count <= drive_item.byte_count;
                    i_bus_status <= drive_item.bus_status;
                    i_in_valid   <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // new burst; a third of the time no gap at all
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern of its own plus one long hold-off
    // ------------------------------------------------------------------

    logic [15:0] rx_cycle  = '0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    always @(posedge i_clk) begin : drive_ready
        rx_cycle <= rx_cycle + 16'd1;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_done && words_in >= 200) begin
            // Long hold-off: the sender keeps going so the block backs up.
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_cycle[8:7])
                2'd0: i_out_ready <= 1'b1;
                2'd1: i_out_ready <= 1'($urandom_range(0, 1));
                2'd2: i_out_ready <= (rx_cycle[1:0] == 2'd0);
                default: i_out_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each action word with the oldest one owed
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : check_actions
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_actions.size() == 0) begin
                $display("%0t: unexpected action word, expected none, actual tx %0h rx %0h",
                         $time, o_tx_byte, o_rx_byte);
                errors++;
            end else begin
                want = owed_actions.pop_front();
                check_field("start_cond", 8'(want.start_cond), 8'(o_start_cond));
                check_field("stop_cond", 8'(want.stop_cond), 8'(o_stop_cond));
                check_field("ack_next", 8'(want.ack_next), 8'(o_ack_next));
                check_field("tx_valid", 8'(want.tx_valid), 8'(o_tx_valid));
                check_field("tx_byte", want.tx_byte, o_tx_byte);
                check_field("rx_valid", 8'(want.rx_valid), 8'(o_rx_valid));
                check_field("rx_index", 8'(want.rx_index), 8'(o_rx_index));
                check_field("rx_byte", want.rx_byte, o_rx_byte);
                check_field("done_res", 8'(want.done_res), 8'(o_done_res));
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no word moves on either side for too long
    // ------------------------------------------------------------------

    int idle_cycles = 0;

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("twi_master_event_sequencer regression: fail");
            $finish;
        end
    end

endmodule
